>>> hw/rtl/sha1md_pkg.sv
// Shared types and constants of the SHA-1 message digest unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sha1md_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_a;
      logic [31:0] digest_b;
      logic [31:0] digest_c;
      logic [31:0] digest_d;
      logic [31:0] digest_e;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        has_byte;
      logic        last;
      logic [63:0] msg_bits;
   } cmd_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;
   localparam logic [4:0][31:0] SHA1_IV = {IV4, IV3, IV2, IV1, IV0};

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

endpackage

>>> hw/rtl/sha1_message_digest_unit.sv
// Top level of the SHA-1 message digest unit: front end, entry queue, back end.
// Depends on sha1md_pkg, sha1md_front, sha1md_queue and sha1md_back.
//
// Each request carries at most one message byte; a request with last set ends
// the message and yields one digest of five 32-bit words, after which the unit
// starts over from the initial vector. The back end absorbs one byte per cycle
// while it is in its byte state and its queue is not empty, and it compresses
// each full 64-byte block in 80 rounds at one round per cycle plus the chaining
// add. Ending a message adds 9 to 72 padding bytes plus one or two block
// compressions before the digest appears. The entry queue of QUEUE_DEPTH
// entries lets requests be taken while the back end compresses, and a finished
// digest waits in its own register while the next message is already accepted.
module sha1_message_digest_unit
   import sha1md_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_push_data;
   cmd_type q_pop_data;

   sha1md_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   sha1md_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   sha1md_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // The back end never takes an entry from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("back end popped an empty queue");

   // The front end never offers an entry that the queue cannot hold.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("front end pushed into a full queue");

   // Requests with neither a byte nor an end of message never reach the queue.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_push_data.has_byte || q_push_data.last))
      else $error("empty request entered the queue");

   // No digest is pending right after reset.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("digest pending after reset");

endmodule

>>> hw/rtl/sha1md_front.sv
// Front end: accepts requests, drops requests that carry neither byte nor end,
// and tags each end-of-message entry with the bit length. Uses sha1md_pkg.
module sha1md_front
   import sha1md_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_data
);

   logic [63:0] bits_ff;
   logic [63:0] bits_in;
   logic [63:0] bits_next;
   logic        accept;

   assign req_full = q_full;
   assign accept = req_push && !q_full;
   assign bits_next = req_data.has_byte ? bits_ff + BITS_PER_BYTE : bits_ff;
   assign q_push = accept && (req_data.has_byte || req_data.last);

   always_comb begin
      q_data.data_byte = req_data.data_byte;
      q_data.has_byte = req_data.has_byte;
      q_data.last = req_data.last;
      q_data.msg_bits = bits_next;
      bits_in = bits_ff;
      if (accept) begin
         bits_in = req_data.last ? '0 : bits_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

endmodule

>>> hw/rtl/sha1md_queue.sv
// Short first-in first-out queue of classified entries between front and back.
// Uses sha1md_pkg for the entry type.
module sha1md_queue
   import sha1md_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff;
   logic [AW-1:0]  wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff;
   logic [AW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           do_push;
   logic           do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/sha1md_back.sv
// Back end: packs bytes into the block, pads the message, runs the 80 rounds
// one per cycle and holds the finished digest. Uses sha1md_pkg.
module sha1md_back
   import sha1md_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam logic [2:0] ST_BYTE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_SUM   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;

   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [2:0] LEN_LAST = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [511:0]     block_ff, block_in;
   logic [63:0]      len_ff, len_in;
   logic [2:0]       len_idx_ff, len_idx_in;
   logic [1:0]       phase_ff, phase_in;
   logic             pad_ff, pad_in;
   logic             fin_ff, fin_in;
   logic [6:0]       round_ff, round_in;
   logic [31:0]      a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]      a_in, b_in, c_in, d_in, e_in;
   logic [4:0][31:0] chain_ff, chain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             absorb;
   logic [7:0]       byte_sel;
   logic [5:0]       cnt_next;
   logic [31:0]      f_val;
   logic [31:0]      k_val;
   logic [31:0]      w_mix;
   logic [31:0]      t_val;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign cnt_next = cnt_ff + 1'b1;

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + block_ff[511:480];
      w_mix = block_ff[95:64] ^ block_ff[255:224] ^ block_ff[447:416] ^ block_ff[511:480];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      block_in = block_ff;
      len_in = len_ff;
      len_idx_in = len_idx_ff;
      phase_in = phase_ff;
      pad_in = pad_ff;
      fin_in = fin_ff;
      round_in = round_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      chain_in = chain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      absorb = 1'b0;
      byte_sel = q_data.data_byte;

      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_BYTE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               absorb = q_data.has_byte;
               if (q_data.last) begin
                  len_in = q_data.msg_bits;
                  len_idx_in = '0;
                  phase_in = PH_MARK;
                  pad_in = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            absorb = 1'b1;
            case (phase_ff)
               PH_MARK: byte_sel = PAD_MARK;
               PH_ZERO: byte_sel = '0;
               default: byte_sel = len_ff[63:56];
            endcase
            if (phase_ff == PH_LEN) begin
               len_in = {len_ff[55:0], 8'd0};
               len_idx_in = len_idx_ff + 1'b1;
               if (len_idx_ff == LEN_LAST) begin
                  fin_in = 1'b1;
               end
            end else begin
               phase_in = (cnt_next == LEN_POS) ? PH_LEN : PH_ZERO;
            end
         end
         ST_ROUND: begin
            a_in = t_val;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            block_in = {block_ff[479:0], w_mix[30:0], w_mix[31]};
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            if (fin_ff) begin
               state_in = ST_DONE;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_BYTE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.digest_a = chain_ff[0];
               rsp_in.digest_b = chain_ff[1];
               rsp_in.digest_c = chain_ff[2];
               rsp_in.digest_d = chain_ff[3];
               rsp_in.digest_e = chain_ff[4];
               chain_in = SHA1_IV;
               cnt_in = '0;
               pad_in = 1'b0;
               fin_in = 1'b0;
               state_in = ST_BYTE;
            end
         end
         default: begin
            state_in = ST_BYTE;
         end
      endcase

      if (absorb) begin
         block_in = {block_ff[503:0], byte_sel};
         cnt_in = cnt_next;
         if (cnt_ff == LAST_BYTE_POS) begin
            a_in = chain_ff[0];
            b_in = chain_ff[1];
            c_in = chain_ff[2];
            d_in = chain_ff[3];
            e_in = chain_ff[4];
            round_in = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BYTE;
         cnt_ff <= '0;
         phase_ff <= PH_MARK;
         len_idx_ff <= '0;
         pad_ff <= 1'b0;
         fin_ff <= 1'b0;
         round_ff <= '0;
         chain_ff <= SHA1_IV;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         phase_ff <= phase_in;
         len_idx_ff <= len_idx_in;
         pad_ff <= pad_in;
         fin_ff <= fin_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      len_ff <= len_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      rsp_ff <= rsp_in;
   end

endmodule
